/* hw/rtl/bgcd_pkg.sv */
// shared constants, stage word type and trailing-zero count for the binary gcd pipeline
package bgcd_pkg;

    localparam int DATA_WIDTH = 64;
    localparam int PORT_W     = 64;
    localparam int CTZ_W      = $clog2(DATA_WIDTH);
    // every step halves the product of the two values, so this bound drives b to zero
    localparam int NUM_STEPS  = 2 * DATA_WIDTH;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] a;
        logic [DATA_WIDTH-1:0] b;
        logic [CTZ_W-1:0]      common;
    } t_stage;

    function automatic logic [CTZ_W-1:0] f_ctz(input logic [DATA_WIDTH-1:0] x);
        logic [DATA_WIDTH-1:0] low;
        logic [CTZ_W-1:0]      n;
        // isolate the lowest set bit, then encode its position
        low = x & (~x + {{(DATA_WIDTH-1){1'b0}}, 1'b1});
        n   = '0;
        for (int i = 0; i < DATA_WIDTH; i++) begin
            if (low[i]) begin
                n = n | CTZ_W'(i);
            end
        end
        return n;
    endfunction

endpackage

/* hw/rtl/bgcd_prep.sv */
// front end: magnitudes, trailing-zero counts and odd-part alignment over three stages
module bgcd_prep (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [bgcd_pkg::DATA_WIDTH-1:0] i_operand_a,
    input  logic [bgcd_pkg::DATA_WIDTH-1:0] i_operand_b,
    output logic                           o_valid,
    output bgcd_pkg::t_stage               o_data
);

    localparam int W = bgcd_pkg::DATA_WIDTH;

    logic                       r_s1_valid, r_s2_valid, r_s3_valid;
    logic [W-1:0]               r_s1_a, r_s1_b;
    logic [W-1:0]               n_s1_a, n_s1_b;
    logic [W-1:0]               r_s2_a, r_s2_b;
    logic [bgcd_pkg::CTZ_W-1:0] r_s2_tza, r_s2_tzb, r_s2_common;
    logic                       r_s2_zero;
    bgcd_pkg::t_stage           r_s3_data, n_s3_data;

    // two's complement magnitude, most negative value comes out as 2^(W-1)
    assign n_s1_a = i_operand_a[W-1] ? (~i_operand_a + {{(W-1){1'b0}}, 1'b1}) : i_operand_a;
    assign n_s1_b = i_operand_b[W-1] ? (~i_operand_b + {{(W-1){1'b0}}, 1'b1}) : i_operand_b;

    always_comb begin
        if (r_s2_zero) begin
            // one operand zero: the other is the answer, b already done
            n_s3_data.a      = r_s2_a | r_s2_b;
            n_s3_data.b      = '0;
            n_s3_data.common = '0;
        end else begin
            n_s3_data.a      = r_s2_a >> r_s2_tza;
            n_s3_data.b      = r_s2_b >> r_s2_tzb;
            n_s3_data.common = r_s2_common;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_a      <= n_s1_a;
            r_s1_b      <= n_s1_b;
            r_s2_a      <= r_s1_a;
            r_s2_b      <= r_s1_b;
            r_s2_tza    <= bgcd_pkg::f_ctz(r_s1_a);
            r_s2_tzb    <= bgcd_pkg::f_ctz(r_s1_b);
            r_s2_common <= bgcd_pkg::f_ctz(r_s1_a | r_s1_b);
            r_s2_zero   <= (r_s1_a == '0) || (r_s1_b == '0);
            r_s3_data   <= n_s3_data;
        end
    end

    assign o_valid = r_s3_valid;
    assign o_data  = r_s3_data;

endmodule

/* hw/rtl/bgcd_step.sv */
// one subtract-or-halve step of the binary gcd, registered
module bgcd_step (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  bgcd_pkg::t_stage i_data,
    output logic             o_valid,
    output bgcd_pkg::t_stage o_data
);

    localparam int W = bgcd_pkg::DATA_WIDTH;

    logic [W:0]       diff_ba;
    logic [W-1:0]     diff_ab;
    logic             r_valid;
    bgcd_pkg::t_stage r_data, n_data;

    assign diff_ba = {1'b0, i_data.b} - {1'b0, i_data.a};
    assign diff_ab = i_data.a - i_data.b;

    // a stays odd (or b is zero); both odd gives an even difference
    always_comb begin
        n_data.common = i_data.common;
        if (!i_data.b[0]) begin
            n_data.a = i_data.a;
            n_data.b = i_data.b >> 1;
        end else if (diff_ba[W]) begin
            n_data.a = i_data.b;
            n_data.b = diff_ab >> 1;
        end else begin
            n_data.a = i_data.a;
            n_data.b = diff_ba[W-1:0] >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* hw/rtl/binary_gcd_64.sv */
// input to output: three front-end stages, one per gcd step, then the output register
// throughput: one word per cycle while the output register is not stalled
// a full output register that is not read stalls the whole pipeline, bubbles are kept
// nothing is dropped; reset: synchronous active-low, clears all valid bits, data registers are not reset
module binary_gcd_64 (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [bgcd_pkg::PORT_W-1:0] i_operand_a,
    input  logic [bgcd_pkg::PORT_W-1:0] i_operand_b,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [bgcd_pkg::PORT_W-1:0] o_gcd_value
);

    localparam int W = bgcd_pkg::DATA_WIDTH;
    localparam int N = bgcd_pkg::NUM_STEPS;

    logic                       en;
    logic                       s_valid [0:N];
    bgcd_pkg::t_stage           s_data  [0:N];
    logic                       r_out_valid;
    logic [bgcd_pkg::PORT_W-1:0] r_gcd, n_gcd;
    logic [W-1:0]               final_val;

    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;

    bgcd_prep u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (i_in_valid),
        .i_operand_a (i_operand_a[W-1:0]),
        .i_operand_b (i_operand_b[W-1:0]),
        .o_valid     (s_valid[0]),
        .o_data      (s_data[0])
    );

    for (genvar k = 0; k < N; k++) begin : g_step
        bgcd_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (s_valid[k]),
            .i_data  (s_data[k]),
            .o_valid (s_valid[k+1]),
            .o_data  (s_data[k+1])
        );
    end

    // b has reached zero, a holds the odd part
    assign final_val = s_data[N].a << s_data[N].common;
    assign n_gcd     = bgcd_pkg::PORT_W'(final_val);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= s_valid[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_gcd <= n_gcd;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_gcd_value = r_gcd;

endmodule

/* hw/rtl/bgcd_chk.sv */
// port-level checker for the binary gcd pipeline, bound to the top level
module bgcd_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic [bgcd_pkg::PORT_W-1:0] i_operand_a,
    input logic [bgcd_pkg::PORT_W-1:0] i_operand_b,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [bgcd_pkg::PORT_W-1:0] o_gcd_value
);

    localparam int W = bgcd_pkg::DATA_WIDTH;

    // a waiting input word stays put
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=>
            i_in_valid && $stable(i_operand_a) && $stable(i_operand_b))
        else $error("input word changed or withdrawn while waiting");

    // a stalled word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_gcd_value))
        else $error("output word changed or dropped while stalled");

    // an empty output register never blocks the input
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output register");

    // a full, stalled output register blocks the input
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input accepted while pipeline stalled");

    // gcd of magnitudes never exceeds 2^(W-1)
    a_gcd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_gcd_value[W-1] && (o_gcd_value[W-2:0] != '0)))
        else $error("gcd above largest magnitude");

endmodule

bind binary_gcd_64 bgcd_chk u_bgcd_chk (.*);
